// File: rtl/core/hsv_wheel_color_map_macros.svh
// Assertion macros for the HSV wheel color map.
`ifndef HSV_WHEEL_COLOR_MAP_MACROS_SVH
`define HSV_WHEEL_COLOR_MAP_MACROS_SVH

`ifndef SYNTH
`define HWCM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hwcm assertion failed");
`define HWCM_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hwcm assertion failed");
`else
`define HWCM_ASSERT(label, clk, rst_n, prop)
`define HWCM_ASSERT_NORST(label, clk, prop)
`endif

`endif

// File: rtl/core/hwcm_pkg.sv
`timescale 1ns / 1ps

package hwcm_pkg;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [16:0] GREY_LIMIT  = 17'd128;
  localparam logic [16:0] HUE_END_RST = 17'h0FFFF;
  localparam logic [2:0]  SECTOR_COUNT = 3'd6;

  typedef enum logic [2:0] {
    CFG_HUE_START = 3'd0,
    CFG_HUE_END   = 3'd1,
    CFG_SAT_START = 3'd2,
    CFG_SAT_END   = 3'd3,
    CFG_VAL_START = 3'd4,
    CFG_VAL_END   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

endpackage

// File: rtl/core/hsv_wheel_color_map.sv
// HSV wheel color map: clamps a Q1.16 level, interpolates H/S/V, converts to RGB.
// Throughput: one word per cycle while the master side accepts; seven register stages,
// each stage holds on a stall while upstream bubbles still collapse, so input is taken as
// long as a slot is free.
// Reset: rst_ni asynchronous active low; clears all stage valids and loads the
// default color registers.
`timescale 1ns / 1ps
`include "hsv_wheel_color_map_macros.svh"

module hsv_wheel_color_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] level, [23:18] zero
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_axis_tuser    // [0] grey_taken
);

  // ---------------------------------------------------------------- config
  logic [16:0] hue_start_q, hue_end_q, sat_start_q, sat_end_q, val_start_q, val_end_q;
  logic [16:0] cfg_sat_d;

  // registers are saturated to 1.0 on write
  assign cfg_sat_d = (cfg_data_i > hwcm_pkg::ONE_Q16) ? hwcm_pkg::ONE_Q16 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_start_q <= '0;
      hue_end_q   <= hwcm_pkg::HUE_END_RST;
      sat_start_q <= hwcm_pkg::ONE_Q16;
      sat_end_q   <= hwcm_pkg::ONE_Q16;
      val_start_q <= hwcm_pkg::ONE_Q16;
      val_end_q   <= hwcm_pkg::ONE_Q16;
    end else if (cfg_we_i) begin
      unique case (hwcm_pkg::cfg_idx_e'(cfg_idx_i))
        hwcm_pkg::CFG_HUE_START: hue_start_q <= cfg_sat_d;
        hwcm_pkg::CFG_HUE_END:   hue_end_q   <= cfg_sat_d;
        hwcm_pkg::CFG_SAT_START: sat_start_q <= cfg_sat_d;
        hwcm_pkg::CFG_SAT_END:   sat_end_q   <= cfg_sat_d;
        hwcm_pkg::CFG_VAL_START: val_start_q <= cfg_sat_d;
        hwcm_pkg::CFG_VAL_END:   val_end_q   <= cfg_sat_d;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- stage handshake
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7 = !v7_q || m_axis_tready;
  assign rdy6 = !v6_q || rdy7;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
    end
  end

  // ---------------------------------------------------- stage 1: clamp level
  logic [17:0] level;
  logic [16:0] zc_d, zc_q1;

  assign level = s_axis_tdata[17:0];

  always_comb begin
    priority if (level[17]) begin
      zc_d = '0;
    end else if (level[16] && (|level[15:0])) begin
      zc_d = hwcm_pkg::ONE_Q16;
    end else begin
      zc_d = level[16:0];
    end
  end

  // -------------------------------------------------- stage 2: interpolate
  // s + (e - s) * z, truncated to Q1.16; never negative for s, e, z in range
  function automatic logic [16:0] lerp(input logic [16:0] s, input logic [16:0] e,
                                       input logic [16:0] z);
    logic signed [17:0] d;
    logic signed [35:0] prod;
    logic signed [35:0] acc;
    d    = $signed({1'b0, e}) - $signed({1'b0, s});
    prod = d * $signed({1'b0, z});
    acc  = $signed({3'b000, s, 16'h0000}) + prod;
    return acc[32:16];
  endfunction

  logic [16:0] hue_d, sat_d, val_d;
  logic [16:0] hue_q2, sat_q2, val_q2;

  assign hue_d = lerp(hue_start_q, hue_end_q, zc_q1);
  assign sat_d = lerp(sat_start_q, sat_end_q, zc_q1);
  assign val_d = lerp(val_start_q, val_end_q, zc_q1);

  // ------------------------------------------ stage 3: sector, fraction, vf
  logic [18:0] h6;
  logic [24:0] vf_full;
  hwcm_pkg::sector_e sector_d, sector_q3, sector_q4, sector_q5, sector_q6;
  logic [15:0] frac_d, frac_q3, frac_q4;
  logic [23:0] vf_d, vf_q3, vf_q4, vf_q5, vf_q6;
  logic [16:0] sat_q3;
  logic grey_d, grey_q3, grey_q4, grey_q5, grey_q6;

  assign h6      = {hue_q2, 2'b00} + {1'b0, hue_q2, 1'b0};
  assign vf_full = {val_q2, 8'h00} - {8'h00, val_q2};
  assign vf_d    = vf_full[23:0];
  assign grey_d  = (sat_q2 <= hwcm_pkg::GREY_LIMIT);

  always_comb begin
    // hue of exactly 1.0 wraps to the first sector
    if (h6[18:16] >= hwcm_pkg::SECTOR_COUNT) begin
      sector_d = hwcm_pkg::SEC_0;
      frac_d   = '0;
    end else begin
      sector_d = hwcm_pkg::sector_e'(h6[18:16]);
      frac_d   = h6[15:0];
    end
  end

  // --------------------------------------------------- stage 4: sv = sat*vf
  logic [40:0] sv_d, sv_q4;

  assign sv_d = {24'h000000, sat_q3} * {17'h00000, vf_q3};

  // ------------------------------------ stage 5: sv*frac split, p byte
  logic [39:0] pl_d, pl_q5;
  logic [32:0] ph_d, ph_q5;
  logic [40:0] pdiff;
  logic [7:0]  p_d, p_q5, p_q6;

  assign pl_d  = {16'h0000, sv_q4[23:0]} * {24'h000000, frac_q4};
  assign ph_d  = {16'h0000, sv_q4[40:24]} * {17'h00000, frac_q4};
  assign pdiff = {1'b0, vf_q4, 16'h0000} - sv_q4;
  assign p_d   = pdiff[39:32];

  // --------------------------------------------- stage 6: svf = sv*frac
  logic [55:0] svf_d, svf_q6;

  // sv stays below 2^40, so the high partial product fits 32 bits
  assign svf_d = {ph_q5[31:0], 24'h000000} + {16'h0000, pl_q5};

  // ----------------------------------------- stage 7: q, t, sector select
  logic [55:0] qdiff;
  logic [7:0]  q_b, t_b, v_b;
  logic [7:0]  red_d, green_d, blue_d;
  logic [7:0]  red_q, green_q, blue_q;
  logic        grey_q7;

  assign qdiff = {vf_q6, 32'h00000000} - svf_q6;
  assign q_b   = qdiff[55:48];
  assign t_b   = p_q6 + svf_q6[55:48];
  assign v_b   = vf_q6[23:16];

  always_comb begin
    red_d   = v_b;
    green_d = v_b;
    blue_d  = v_b;
    if (!grey_q6) begin
      unique case (sector_q6)
        hwcm_pkg::SEC_0: begin red_d = v_b;  green_d = t_b;  blue_d = p_q6; end
        hwcm_pkg::SEC_1: begin red_d = q_b;  green_d = v_b;  blue_d = p_q6; end
        hwcm_pkg::SEC_2: begin red_d = p_q6; green_d = v_b;  blue_d = t_b;  end
        hwcm_pkg::SEC_3: begin red_d = p_q6; green_d = q_b;  blue_d = v_b;  end
        hwcm_pkg::SEC_4: begin red_d = t_b;  green_d = p_q6; blue_d = v_b;  end
        default:         begin red_d = v_b;  green_d = p_q6; blue_d = q_b;  end
      endcase
    end
  end

  // ---------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) zc_q1 <= zc_d;
    if (rdy2) begin
      hue_q2 <= hue_d;
      sat_q2 <= sat_d;
      val_q2 <= val_d;
    end
    if (rdy3) begin
      sector_q3 <= sector_d;
      frac_q3   <= frac_d;
      vf_q3     <= vf_d;
      sat_q3    <= sat_q2;
      grey_q3   <= grey_d;
    end
    if (rdy4) begin
      sector_q4 <= sector_q3;
      frac_q4   <= frac_q3;
      vf_q4     <= vf_q3;
      grey_q4   <= grey_q3;
      sv_q4     <= sv_d;
    end
    if (rdy5) begin
      sector_q5 <= sector_q4;
      vf_q5     <= vf_q4;
      grey_q5   <= grey_q4;
      pl_q5     <= pl_d;
      ph_q5     <= ph_d;
      p_q5      <= p_d;
    end
    if (rdy6) begin
      sector_q6 <= sector_q5;
      vf_q6     <= vf_q5;
      grey_q6   <= grey_q5;
      p_q6      <= p_q5;
      svf_q6    <= svf_d;
    end
    if (rdy7) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      grey_q7 <= grey_q6;
    end
  end

  assign m_axis_tvalid = v7_q;
  assign m_axis_tdata  = {blue_q, green_q, red_q};
  assign m_axis_tuser  = grey_q7;

  // ------------------------------------------------------------ assertions
  `HWCM_ASSERT(a_neg_level_clamps, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready && s_axis_tdata[17]) |=> (zc_q1 == '0))
  `HWCM_ASSERT(a_sector_wrapped, clk_i, rst_ni,
               v3_q |-> (sector_q3 < hwcm_pkg::SECTOR_COUNT))
  `HWCM_ASSERT(a_grey_is_flat, clk_i, rst_ni,
               (m_axis_tvalid && m_axis_tuser) |->
               ((m_axis_tdata[7:0] == m_axis_tdata[15:8]) &&
                (m_axis_tdata[15:8] == m_axis_tdata[23:16])))
  `HWCM_ASSERT(a_stage6_holds, clk_i, rst_ni,
               (v6_q && !rdy7) |=> (v6_q && $stable(svf_q6)))

endmodule

// File: verif/hsv_wheel_color_map_tb.sv
`timescale 1ns / 1ps

module hsv_wheel_color_map_tb;

  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 250000;
  localparam int REPORT_MAX = 10;
  localparam int SWEEP_PHASES = 6;
  localparam int PHASE_WORDS = 75;
  // indexes past the register file; writes there must be dropped
  localparam logic [2:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_IDX_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       grey;
  } rgb_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [17:0] level, [23:18] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue
  logic        m_axis_tuser;        // [0] grey_taken

  rgb_t        rgb_expected_q[$];
  logic [16:0] color_reg [6];
  int          fail_cnt = 0;
  int          cyc_cnt = 0;
  int          ready_hold = 0;
  bit          steady_tx = 1'b0;
  bit          steady_rx = 1'b0;

  hsv_wheel_color_map dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- color predictor

  // start + (end - start) * z, truncated to Q1.16; registers clip at 1.0
  function automatic logic [16:0] lerp_q16(input logic [16:0] a, input logic [16:0] b,
                                           input logic [16:0] zc);
    longint s;
    longint e;
    longint z;
    longint acc;
    s = (a > hwcm_pkg::ONE_Q16) ? hwcm_pkg::ONE_Q16 : a;
    e = (b > hwcm_pkg::ONE_Q16) ? hwcm_pkg::ONE_Q16 : b;
    z = zc;
    acc = s * 65536 + (e - s) * z;
    if (acc < 0) acc = 0;
    return 17'(acc >>> 16);
  endfunction

  function automatic rgb_t predict_rgb(input logic [17:0] lvl);
    logic [16:0] zc;
    logic [16:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
    logic [19:0] h6;
    logic [2:0]  sec;
    logic [15:0] frac;
    logic [63:0] vf;
    logic [63:0] sv;
    logic [63:0] svf;
    logic [63:0] tmp;
    logic [7:0]  vv;
    logic [7:0]  pv;
    logic [7:0]  qv;
    logic [7:0]  tv;
    rgb_t        res;
    if (lvl[17]) zc = '0;
    else if (lvl > hwcm_pkg::ONE_Q16) zc = hwcm_pkg::ONE_Q16;
    else zc = lvl[16:0];

    sat = lerp_q16(color_reg[hwcm_pkg::CFG_SAT_START], color_reg[hwcm_pkg::CFG_SAT_END], zc);
    val = lerp_q16(color_reg[hwcm_pkg::CFG_VAL_START], color_reg[hwcm_pkg::CFG_VAL_END], zc);
    vf = 64'(val) * 64'd255;

    if (sat <= hwcm_pkg::GREY_LIMIT) begin
      res.red = vf[23:16];
      res.green = vf[23:16];
      res.blue = vf[23:16];
      res.grey = 1'b1;
      return res;
    end

    hue = lerp_q16(color_reg[hwcm_pkg::CFG_HUE_START], color_reg[hwcm_pkg::CFG_HUE_END], zc);
    h6 = 20'(hue) * 20'd6;
    sec = h6[18:16];
    frac = h6[15:0];
    // hue of exactly one turn lands on sector six: wrap to red
    if (sec >= hwcm_pkg::SECTOR_COUNT) begin
      sec = hwcm_pkg::SEC_0;
      frac = '0;
    end

    sv = 64'(sat) * vf;
    svf = sv * 64'(frac);
    vv = vf[23:16];
    tmp = ((vf << 16) - sv) >> 32;
    pv = tmp[7:0];
    tmp = ((vf << 32) - svf) >> 48;
    qv = tmp[7:0];
    tv = pv + svf[55:48];

    case (sec)
      hwcm_pkg::SEC_0: begin res.red = vv; res.green = tv; res.blue = pv; end
      hwcm_pkg::SEC_1: begin res.red = qv; res.green = vv; res.blue = pv; end
      hwcm_pkg::SEC_2: begin res.red = pv; res.green = vv; res.blue = tv; end
      hwcm_pkg::SEC_3: begin res.red = pv; res.green = qv; res.blue = vv; end
      hwcm_pkg::SEC_4: begin res.red = tv; res.green = pv; res.blue = vv; end
      default: begin res.red = vv; res.green = pv; res.blue = qv; end
    endcase
    res.grey = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------- flow control

  function automatic int hold_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int tx_gap();
    int r;
    if (steady_tx) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (steady_rx) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold == 0) begin
      m_axis_tready <= ($urandom_range(0, 9) < 7);
      ready_hold = hold_len();
    end else begin
      ready_hold--;
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- scoreboard

  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.red = m_axis_tdata[7:0];
        got.green = m_axis_tdata[15:8];
        got.blue = m_axis_tdata[23:16];
        got.grey = m_axis_tuser;
        if (rgb_expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("%0t: unexpected word rgb=%02h %02h %02h grey=%0b", $realtime,
                     got.red, got.green, got.blue, got.grey);
        end else begin
          want = rgb_expected_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.grey !== want.grey) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display("%0t: mismatch exp rgb=%02h %02h %02h grey=%0b, got %02h %02h %02h grey=%0b",
                       $realtime, want.red, want.green, want.blue, want.grey,
                       got.red, got.green, got.blue, got.grey);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        rgb_expected_q.push_back(predict_rgb(s_axis_tdata[17:0]));
    end
  end

  // ---------------------------------------------------------------- driver tasks

  // leaves tvalid high after the accepting edge so words can go back to back
  task automatic send_level(input logic [17:0] lvl);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (rgb_expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= hwcm_pkg::CFG_VAL_END) color_reg[idx] = data;
    @(posedge clk_i);
  endtask

  task automatic write_colors(input logic [16:0] hs, input logic [16:0] he,
                              input logic [16:0] ss, input logic [16:0] se,
                              input logic [16:0] vs, input logic [16:0] ve);
    write_reg(hwcm_pkg::CFG_HUE_START, hs);
    write_reg(hwcm_pkg::CFG_HUE_END, he);
    write_reg(hwcm_pkg::CFG_SAT_START, ss);
    write_reg(hwcm_pkg::CFG_SAT_END, se);
    write_reg(hwcm_pkg::CFG_VAL_START, vs);
    write_reg(hwcm_pkg::CFG_VAL_END, ve);
  endtask

  function automatic logic [16:0] rand_reg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return hwcm_pkg::ONE_Q16;
    if (r < 22) return 17'h1FFFF;
    if (r < 40) return 17'($urandom);
    return 17'($urandom_range(0, 65536));
  endfunction

  function automatic logic [17:0] rand_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 18'($urandom);
    if (r < 20) return 18'($urandom_range(0, 8));
    if (r < 28) return 18'($urandom_range(65528, 65544));
    if (r < 32) return 18'h3FFFF - 18'($urandom_range(0, 8));
    return 18'($urandom_range(0, 65536));
  endfunction

  // ---------------------------------------------------------------- tests

  // reset palette, level at and beyond both ends of the range
  task automatic test_level_clamp();
    send_level(18'd0);
    send_level(18'd1);
    send_level(18'd32768);
    send_level(18'd65535);
    send_level(18'd65536);
    send_level(18'd65537);
    send_level(18'h1FFFF);   // most positive
    send_level(18'h3FFFF);   // -1
    send_level(18'h20000);   // most negative
  endtask

  // one word in each of the six sectors of a full wheel
  task automatic test_sectors();
    wait_idle();
    write_colors('0, hwcm_pkg::ONE_Q16, hwcm_pkg::ONE_Q16, hwcm_pkg::ONE_Q16,
                 hwcm_pkg::ONE_Q16, hwcm_pkg::ONE_Q16);
    send_level(18'd5000);
    send_level(18'd16000);
    send_level(18'd27000);
    send_level(18'd38000);
    send_level(18'd49000);
    send_level(18'd60000);
  endtask

  task automatic test_full_hue_wrap();
    send_level(18'd65536);
    wait_idle();
    write_reg(hwcm_pkg::CFG_HUE_START, hwcm_pkg::ONE_Q16);
    write_reg(hwcm_pkg::CFG_HUE_END, hwcm_pkg::ONE_Q16);
    send_level(18'd20000);
  endtask

  // saturation 128 is still grey, 129 is not
  task automatic test_grey_branch();
    wait_idle();
    write_colors(17'd9000, 17'd50000, 17'd128, 17'd129, hwcm_pkg::ONE_Q16,
                 hwcm_pkg::ONE_Q16);
    send_level(18'd0);
    send_level(18'd65536);
    wait_idle();
    write_colors('0, hwcm_pkg::ONE_Q16, '0, '0, '0, hwcm_pkg::ONE_Q16);
    send_level(18'd32768);
  endtask

  task automatic test_reg_saturation();
    wait_idle();
    write_colors(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_level(18'd0);
    send_level(18'd40000);
  endtask

  task automatic test_unknown_index();
    wait_idle();
    write_colors(17'd3000, 17'd61000, 17'd20000, hwcm_pkg::ONE_Q16, 17'd30000,
                 hwcm_pkg::ONE_Q16);
    write_reg(CFG_IDX_SPARE_A, '0);
    write_reg(CFG_IDX_SPARE_B, 17'h1FFFF);
    send_level(18'd30000);
  endtask

  task automatic test_random_sweep();
    for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
      wait_idle();
      write_colors(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
      // every third phase pulls saturation down around the grey threshold
      if (ph % 3 == 2) begin
        write_reg(hwcm_pkg::CFG_SAT_START, 17'($urandom_range(0, 400)));
        write_reg(hwcm_pkg::CFG_SAT_END, 17'($urandom_range(0, 400)));
      end
      steady_tx = (ph == 1);
      steady_rx = (ph == 1 || ph == 4);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 2 && i == PHASE_WORDS / 2) wait_idle();
        send_level(rand_level());
      end
    end
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  initial begin
    color_reg[hwcm_pkg::CFG_HUE_START] = '0;
    color_reg[hwcm_pkg::CFG_HUE_END] = hwcm_pkg::HUE_END_RST;
    color_reg[hwcm_pkg::CFG_SAT_START] = hwcm_pkg::ONE_Q16;
    color_reg[hwcm_pkg::CFG_SAT_END] = hwcm_pkg::ONE_Q16;
    color_reg[hwcm_pkg::CFG_VAL_START] = hwcm_pkg::ONE_Q16;
    color_reg[hwcm_pkg::CFG_VAL_END] = hwcm_pkg::ONE_Q16;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_level_clamp();
    test_sectors();
    test_full_hue_wrap();
    test_grey_branch();
    test_reg_saturation();
    test_unknown_index();
    test_random_sweep();
    wait_idle();

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
